FILE: design/tea_block_cipher_unit_defines.svh
// assertion macros for the tea block cipher unit
// used by tea_block_cipher_unit, expects clk_i and rst_ni in scope
`ifndef TEA_BLOCK_CIPHER_UNIT_DEFINES_SVH
`define TEA_BLOCK_CIPHER_UNIT_DEFINES_SVH

// same-cycle implication
`define TEA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TEA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/tea_pkg.sv
// shared types and constants of the tea block cipher unit
// used by tea_half_round and tea_block_cipher_unit, depends on nothing
package tea_pkg;

  localparam logic [31:0] TeaDelta = 32'h9E3779B9;

  localparam int unsigned CfgIdxW = 8;

  localparam logic [CfgIdxW-1:0] CFG_KEY_WORD_ZERO  = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_KEY_WORD_ONE   = 8'd1;
  localparam logic [CfgIdxW-1:0] CFG_KEY_WORD_TWO   = 8'd2;
  localparam logic [CfgIdxW-1:0] CFG_KEY_WORD_THREE = 8'd3;

  typedef enum logic {
    OP_ENCRYPT = 1'b0,
    OP_DECRYPT = 1'b1
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [31:0] word_first;
    logic [31:0] word_second;
  } blk_t;

  typedef struct packed {
    logic [31:0] k0;
    logic [31:0] k1;
    logic [31:0] k2;
    logic [31:0] k3;
  } key_t;

endpackage

FILE: design/tea_half_round.sv
// one registered half round of tea, one word updated per stage
// depends on tea_pkg for the block and key types
module tea_half_round #(
  parameter logic [31:0] SumEnc    = 32'h9E3779B9,
  parameter logic [31:0] SumDec    = 32'h9E3779B9,
  parameter bit          FirstHalf = 1'b1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  tea_pkg::blk_t blk_i,
  input  tea_pkg::key_t key_i,
  output logic          valid_o,
  input  logic          ready_i,
  output tea_pkg::blk_t blk_o
);

  logic          valid_q;
  tea_pkg::blk_t blk_q, blk_d;
  logic          is_dec, alter_first;
  logic [31:0]   src, dst, kl, kr, sum, mix, res;

  always_comb begin
    is_dec      = (blk_i.op == tea_pkg::OP_DECRYPT);
    alter_first = (FirstHalf == !is_dec);
    src         = alter_first ? blk_i.word_second : blk_i.word_first;
    dst         = alter_first ? blk_i.word_first : blk_i.word_second;
    kl          = alter_first ? key_i.k0 : key_i.k2;
    kr          = alter_first ? key_i.k1 : key_i.k3;
    sum         = is_dec ? SumDec : SumEnc;
    mix         = ((src << 4) + kl) ^ (src + sum) ^ ((src >> 5) + kr);
    res         = is_dec ? (dst - mix) : (dst + mix);
    blk_d       = blk_i;
    if (alter_first) begin
      blk_d.word_first = res;
    end else begin
      blk_d.word_second = res;
    end
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign blk_o   = blk_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      blk_q <= blk_d;
    end
  end

endmodule

FILE: design/tea_block_cipher_unit.sv
// tea block cipher unit, ecb encrypt or decrypt of one 64-bit block per beat
// depends on tea_pkg, tea_half_round and tea_block_cipher_unit_defines.svh
//
//   channel  direction  handshake              payload
//   in       sink       in_valid_i/in_ready_o  opcode_i, word_first_i, word_second_i
//   out      source     out_valid_o/out_ready_i result_first_o, result_second_o
//   cfg      sink       cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// one register per half round
// one beat per cycle in and out while the output side keeps taking
// reset clears the stage valid bits and the four key words
// a full stage holds while the one after it is full and holding, empty stages close up
`include "tea_block_cipher_unit_defines.svh"

module tea_block_cipher_unit #(
  parameter int unsigned CYCLE_COUNT = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         opcode_i,
  input  logic [31:0]                  word_first_i,
  input  logic [31:0]                  word_second_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [31:0]                  result_first_o,
  output logic [31:0]                  result_second_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [tea_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [31:0]                  cfg_data_i
);

  localparam int unsigned NumStages = 2 * CYCLE_COUNT;

  tea_pkg::key_t key_q;
  logic [NumStages:0] vld;
  logic [NumStages:0] rdy;
  tea_pkg::blk_t      blk [NumStages+1];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        tea_pkg::CFG_KEY_WORD_ZERO:  key_q.k0 <= cfg_data_i;
        tea_pkg::CFG_KEY_WORD_ONE:   key_q.k1 <= cfg_data_i;
        tea_pkg::CFG_KEY_WORD_TWO:   key_q.k2 <= cfg_data_i;
        tea_pkg::CFG_KEY_WORD_THREE: key_q.k3 <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign vld[0]             = in_valid_i;
  assign in_ready_o         = rdy[0];
  assign blk[0].op          = tea_pkg::op_e'(opcode_i);
  assign blk[0].word_first  = word_first_i;
  assign blk[0].word_second = word_second_i;

  for (genvar h = 0; h < NumStages; h++) begin : g_stage
    localparam int unsigned Rnd = h / 2;
    localparam logic [31:0] SumEnc =
      32'(64'(tea_pkg::TeaDelta) * 64'(Rnd + 1));
    localparam logic [31:0] SumDec =
      32'(64'(tea_pkg::TeaDelta) * 64'(CYCLE_COUNT - Rnd));

    tea_half_round #(
      .SumEnc    (SumEnc),
      .SumDec    (SumDec),
      .FirstHalf ((h % 2) == 0)
    ) u_round (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld[h]),
      .ready_o (rdy[h]),
      .blk_i   (blk[h]),
      .key_i   (key_q),
      .valid_o (vld[h+1]),
      .ready_i (rdy[h+1]),
      .blk_o   (blk[h+1])
    );
  end

  assign rdy[NumStages]  = out_ready_i;
  assign out_valid_o     = vld[NumStages];
  assign result_first_o  = blk[NumStages].word_first;
  assign result_second_o = blk[NumStages].word_second;

  `TEA_ASSERT_NOW(a_stall_means_full, !in_ready_o,
    (&vld[NumStages:1]) && !out_ready_i, "input stalled with a free stage")
  `TEA_ASSERT_NOW(a_drain_frees_input, out_ready_i, in_ready_o,
    "input stalled while output drains")
  `TEA_ASSERT_NEXT(a_beat_enters, in_valid_i && in_ready_o, vld[1],
    "accepted beat missing from first stage")

endmodule
